@@ rtl/slt_pkg.sv @@
package slt_pkg;

	localparam logic [2:0] OP_INSERT  = 3'd0;
	localparam logic [2:0] OP_LOOKUP  = 3'd1;
	localparam logic [2:0] OP_REMOVE  = 3'd2;
	localparam logic [2:0] OP_EXTRACT = 3'd3;
	localparam logic [2:0] OP_COUNT   = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;

	typedef enum logic [1:0] {
		EDIT_NONE,
		EDIT_INSERT,
		EDIT_DROP_LT,
		EDIT_DROP_POS
	} edit_t;

	// controller -> datapath
	typedef struct packed {
		logic                load;
		logic                compare;
		logic                commit;
		edit_t               edit;
		logic [STATUS_W-1:0] status;
		logic                found;
		logic                take_value;
	} slt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [OP_W-1:0] opcode;
		logic            empty;
		logic            full;
		logic            hit;
		logic            beyond;
	} slt_sts_t;

endpackage

@@ rtl/slt_ctrl.sv @@
module slt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  slt_pkg::slt_sts_t sts,
	output slt_pkg::slt_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_COMP,
		S_APPLY
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign out_free  = !out_valid_q || rsp_ready;

	always_comb begin
		cmd            = '0;
		cmd.edit       = slt_pkg::EDIT_NONE;
		cmd.status     = slt_pkg::ST_OK;
		cmd.load       = (state_q == S_IDLE) && req_valid;
		cmd.compare    = (state_q == S_COMP);
		cmd.commit     = (state_q == S_APPLY) && out_free;
		unique case (sts.opcode)
			slt_pkg::OP_INSERT: begin
				if (sts.full) begin
					cmd.status = slt_pkg::ST_FULL;
				end else begin
					cmd.edit = slt_pkg::EDIT_INSERT;
				end
			end
			slt_pkg::OP_LOOKUP: begin
				if (sts.empty) begin
					cmd.status = slt_pkg::ST_EMPTY;
				end else if (!sts.hit) begin
					cmd.status = slt_pkg::ST_NOTFOUND;
				end else begin
					cmd.found = 1'b1;
				end
			end
			slt_pkg::OP_REMOVE: begin
				if (sts.empty) begin
					cmd.status = slt_pkg::ST_EMPTY;
				end else if (!sts.hit) begin
					cmd.status = slt_pkg::ST_NOTFOUND;
				end else begin
					cmd.edit = slt_pkg::EDIT_DROP_LT;
				end
			end
			slt_pkg::OP_EXTRACT: begin
				if (sts.empty) begin
					cmd.status = slt_pkg::ST_EMPTY;
				end else if (sts.beyond) begin
					cmd.status = slt_pkg::ST_RANGE;
				end else begin
					cmd.edit       = slt_pkg::EDIT_DROP_POS;
					cmd.take_value = 1'b1;
				end
			end
			default: begin
				// count and unused opcodes: report only
				cmd.status = slt_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_COMP;
					if (rsp_ready) out_valid_q <= 1'b0;
				end
				S_COMP: begin
					state_q <= S_APPLY;
					if (rsp_ready) out_valid_q <= 1'b0;
				end
				S_APPLY: begin
					// hold until the result register is free
					if (out_free) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/slt_dp.sv @@
module slt_dp #(
	parameter int CAPACITY = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [slt_pkg::OP_W-1:0]             opcode,
	input  logic signed [slt_pkg::VALUE_W-1:0]   value,
	input  logic [slt_pkg::POS_W-1:0]            position,
	input  slt_pkg::slt_cmd_t                    cmd,
	output slt_pkg::slt_sts_t                    sts,
	output logic [slt_pkg::STATUS_W-1:0]         status,
	output logic                                 found,
	output logic [slt_pkg::POS_W-1:0]            found_index,
	output logic signed [slt_pkg::VALUE_W-1:0]   extracted_value,
	output logic [slt_pkg::COUNT_W-1:0]          count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = slt_pkg::POS_W;
	localparam int VW = slt_pkg::VALUE_W;

	logic [slt_pkg::OP_W-1:0] op_q;
	logic signed [VW-1:0]     value_q;
	logic [PW-1:0]            pos_q;

	logic signed [VW-1:0]     entry_q   [CAPACITY];
	logic signed [VW-1:0]     entry_nxt [CAPACITY];
	logic [CAPACITY-1:0]      lt_q;
	logic [CAPACITY-1:0]      eq_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_nxt;

	logic [CAPACITY-1:0]      cell_valid;
	logic [CAPACITY-1:0]      first_ge;
	logic [CAPACITY-1:0]      hit_vec;
	logic [CAPACITY-1:0]      pos_sel;
	logic [CAPACITY-1:0]      pos_before;
	logic [PW-1:0]            hit_index;
	logic signed [VW-1:0]     pos_value;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_valid[i] = CW'(i) < count_q;
			pos_sel[i]    = (i < (1 << PW)) && (pos_q == PW'(i));
			pos_before[i] = (i < (1 << PW)) && (PW'(i) < pos_q);
		end
	end

	// boundary cell: first one not below the key
	always_comb begin
		logic prev_lt;
		prev_lt = 1'b1;
		for (int i = 0; i < CAPACITY; i++) begin
			first_ge[i] = cell_valid[i] && !lt_q[i] && prev_lt;
			prev_lt     = lt_q[i];
		end
	end

	assign hit_vec = first_ge & eq_q;

	always_comb begin
		hit_index = '0;
		pos_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit_vec[i]) hit_index = hit_index | PW'(i);
			if (pos_sel[i]) pos_value = pos_value | entry_q[i];
		end
	end

	assign sts.opcode = op_q;
	assign sts.empty  = (count_q == '0);
	assign sts.full   = (count_q == CW'(CAPACITY));
	assign sts.hit    = |hit_vec;
	assign sts.beyond = (PW + CW)'(pos_q) >= (PW + CW)'(count_q);

	always_comb begin
		logic prev_lt;
		prev_lt = 1'b1;
		for (int i = 0; i < CAPACITY; i++) begin
			entry_nxt[i] = entry_q[i];
			unique case (cmd.edit)
				slt_pkg::EDIT_INSERT: begin
					if (lt_q[i]) begin
						entry_nxt[i] = entry_q[i];
					end else if (prev_lt) begin
						entry_nxt[i] = value_q;
					end else begin
						entry_nxt[i] = entry_q[(i > 0) ? i - 1 : 0];
					end
				end
				slt_pkg::EDIT_DROP_LT: begin
					if (!lt_q[i] && (i + 1 < CAPACITY)) begin
						entry_nxt[i] = entry_q[(i + 1 < CAPACITY) ? i + 1 : i];
					end
				end
				slt_pkg::EDIT_DROP_POS: begin
					if (!pos_before[i] && (i + 1 < CAPACITY)) begin
						entry_nxt[i] = entry_q[(i + 1 < CAPACITY) ? i + 1 : i];
					end
				end
				default: begin
					entry_nxt[i] = entry_q[i];
				end
			endcase
			prev_lt = lt_q[i];
		end
	end

	always_comb begin
		unique case (cmd.edit)
			slt_pkg::EDIT_INSERT:   count_nxt = count_q + CW'(1);
			slt_pkg::EDIT_DROP_LT:  count_nxt = count_q - CW'(1);
			slt_pkg::EDIT_DROP_POS: count_nxt = count_q - CW'(1);
			default:                count_nxt = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			value_q <= value;
			pos_q   <= position;
		end
		if (cmd.compare) begin
			for (int i = 0; i < CAPACITY; i++) begin
				lt_q[i] <= cell_valid[i] && (entry_q[i] < value_q);
				eq_q[i] <= (entry_q[i] == value_q);
			end
		end
		if (cmd.commit) begin
			for (int i = 0; i < CAPACITY; i++) begin
				entry_q[i] <= entry_nxt[i];
			end
			status          <= cmd.status;
			found           <= cmd.found;
			found_index     <= cmd.found ? hit_index : '0;
			extracted_value <= cmd.take_value ? pos_value : '0;
			count           <= slt_pkg::COUNT_W'(count_nxt);
		end
	end

endmodule

@@ rtl/sorted_list_table.sv @@
// Sorted table of signed 32-bit values, kept in ascending order; equal values
// keep arrival order with the newest one first among its equals.
// Request channel (req_valid/req_ready): opcode, value, position. Opcodes are
// insert, lookup, remove value, extract at position and count; codes five to
// seven act as count. Response channel (rsp_valid/rsp_ready): one response
// per request with status, found, found_index, extracted_value and count,
// where count is the number of stored values after the operation.
// Timing: a request is taken in the idle step, every stored cell compares against
// it in the compare step, and the edit plus the response register load happen in
// the apply step. rsp_valid rises as the controller returns to idle, and only then
// is a new request accepted: a request finishes its apply step before the next one
// is taken. The three-step controller sequence sets this order.
// A waiting response does not block acceptance of the next request; that
// request holds in its final step until the response register is taken.
// Reset empties the table (count zero), clears rsp_valid and leaves req_ready
// high; stored values are not cleared, and unwritten cells never reach a response.
module sorted_list_table #(
	parameter int CAPACITY = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  logic [slt_pkg::OP_W-1:0]             opcode,
	input  logic signed [slt_pkg::VALUE_W-1:0]   value,
	input  logic [slt_pkg::POS_W-1:0]            position,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output logic [slt_pkg::STATUS_W-1:0]         status,
	output logic                                 found,
	output logic [slt_pkg::POS_W-1:0]            found_index,
	output logic signed [slt_pkg::VALUE_W-1:0]   extracted_value,
	output logic [slt_pkg::COUNT_W-1:0]          count
);

	slt_pkg::slt_cmd_t cmd;
	slt_pkg::slt_sts_t sts;

	slt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	slt_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.opcode          (opcode),
		.value           (value),
		.position        (position),
		.cmd             (cmd),
		.sts             (sts),
		.status          (status),
		.found           (found),
		.found_index     (found_index),
		.extracted_value (extracted_value),
		.count           (count)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while another is in progress");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && found) |-> (status == slt_pkg::ST_OK))
		else $error("found flag with a failing status");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == slt_pkg::ST_EMPTY) |-> (count == '0))
		else $error("empty status with nonzero count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == slt_pkg::ST_FULL)
		|-> (count == slt_pkg::COUNT_W'(CAPACITY)))
		else $error("full status below capacity");

endmodule
